FILE: hdl/lifet_pkg.sv
`default_nettype none
package lifet_pkg;

  localparam int WORD_W    = 32;
  localparam int FRAC_BITS = 15;
  localparam int CNT_W     = 16;
  localparam int DECAY_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int OP_W      = WORD_W + 1;
  localparam int PROD_W    = 2 * OP_W;
  localparam int SUM_W     = WORD_W + 2;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [OP_W-1:0]   op_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam word_t FX_ONE   = word_t'(1) <<< FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REST_V    = 3'd0,
    REG_RESET_V   = 3'd1,
    REG_OFFSET_I  = 3'd2,
    REG_RESIST    = 3'd3,
    REG_MEM_DECAY = 3'd4,
    REG_ERR_DECAY = 3'd5,
    REG_REFRAC    = 3'd6
  } cfg_idx_t;

  function automatic word_t sat_sum(input sum_t v);
    logic [SUM_W-WORD_W:0] hi;
    hi = v[SUM_W-1:WORD_W-1];
    if (hi == '0 || hi == '1) return v[WORD_W-1:0];
    else if (v[SUM_W-1]) return WORD_MIN;
    else return WORD_MAX;
  endfunction

  function automatic sum_t sx(input word_t v);
    return sum_t'(v);
  endfunction

endpackage
`default_nettype wire

FILE: hdl/lifet_in_if.sv
`default_nettype none
interface lifet_in_if;
  logic                   valid;
  logic                   ready;
  logic                   mode;
  lifet_pkg::word_t       excitatory_current;
  lifet_pkg::word_t       inhibitory_current;
  lifet_pkg::word_t       bias_current;

  modport source(output valid, mode, excitatory_current, inhibitory_current, bias_current,
                 input ready);
  modport sink(input valid, mode, excitatory_current, inhibitory_current, bias_current,
               output ready);
endinterface
`default_nettype wire

FILE: hdl/lifet_out_if.sv
`default_nettype none
interface lifet_out_if;
  logic                   valid;
  logic                   ready;
  lifet_pkg::word_t       membrane_voltage;
  lifet_pkg::word_t       error_trace;

  modport source(output valid, membrane_voltage, error_trace, input ready);
  modport sink(input valid, membrane_voltage, error_trace, output ready);
endinterface
`default_nettype wire

FILE: hdl/lifet_mul.sv
`default_nettype none
// shared multiply, floor shift by the fraction width, saturate
module lifet_mul (
  input  wire logic             clk,
  input  wire lifet_pkg::op_t   op_a,
  input  wire lifet_pkg::op_t   op_b,
  output lifet_pkg::word_t      res
);

  lifet_pkg::prod_t prod_r;
  lifet_pkg::prod_t shifted;
  logic [lifet_pkg::PROD_W-lifet_pkg::WORD_W:0] hi;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  always_comb begin
    shifted = prod_r >>> lifet_pkg::FRAC_BITS;
    hi      = shifted[lifet_pkg::PROD_W-1:lifet_pkg::WORD_W-1];
    if (hi == '0 || hi == '1) res = shifted[lifet_pkg::WORD_W-1:0];
    else if (shifted[lifet_pkg::PROD_W-1]) res = lifet_pkg::WORD_MIN;
    else res = lifet_pkg::WORD_MAX;
  end

endmodule
`default_nettype wire

FILE: hdl/lif_neuron_with_error_trace_core.sv
`default_nettype none
// channel  dir  handshake      payload
// in_if    in   valid/ready    mode, excitatory/inhibitory/bias current
// out_if   out  valid/ready    membrane_voltage, error_trace
// cfg_*    in   cfg_we only    cfg_index, cfg_wdata
//
// Timestep item: ST_SUM, ST_MUL_R, ST_ALPHA, ST_DIFF, ST_MUL_D, ST_VOLT,
// ST_ERR_WB, ST_FIN; refractory timestep ST_MUL_E, ST_ERR_WB, ST_FIN; spike
// event ST_FIN. Next item accepted after the result loads. Synchronous
// active-low reset resets only control, state and config registers.
// A waiting result holds the sequencer in its last state; in_if.ready stays
// high while the result register is full and the block is otherwise idle.
module lif_neuron_with_error_trace_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  lifet_in_if.sink                               in_if,
  lifet_out_if.source                            out_if,
  input  wire logic                              cfg_we,
  input  wire logic [lifet_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lifet_pkg::WORD_W-1:0]      cfg_wdata
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_SUM    = 10'b0000000010,
    ST_MUL_R  = 10'b0000000100,
    ST_ALPHA  = 10'b0000001000,
    ST_DIFF   = 10'b0000010000,
    ST_MUL_D  = 10'b0000100000,
    ST_VOLT   = 10'b0001000000,
    ST_MUL_E  = 10'b0010000000,
    ST_ERR_WB = 10'b0100000000,
    ST_FIN    = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  lifet_pkg::word_t rest_r, reset_v_r, offset_r, resist_r;
  logic [lifet_pkg::DECAY_W-1:0] mdecay_r, edecay_r;
  logic [lifet_pkg::CNT_W-1:0]   refrac_r;

  lifet_pkg::word_t voltage_r, voltage_nxt;
  lifet_pkg::word_t error_r, error_nxt;
  logic [lifet_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  lifet_pkg::word_t exc_r, inh_r, bias_r;
  lifet_pkg::word_t work_r, work_nxt;
  lifet_pkg::word_t alpha_r, alpha_nxt;

  logic             out_valid_r, out_valid_nxt;
  lifet_pkg::word_t out_v_r, out_e_r;

  lifet_pkg::op_t   op_a, op_b;
  lifet_pkg::word_t mul_res;

  logic in_acc, slot_free;

  assign in_if.ready         = (state_r == ST_IDLE);
  assign in_acc              = in_if.valid && in_if.ready;
  assign slot_free           = !out_valid_r || out_if.ready;
  assign out_if.valid        = out_valid_r;
  assign out_if.membrane_voltage = out_v_r;
  assign out_if.error_trace  = out_e_r;

  lifet_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .res  (mul_res)
  );

  always_comb begin
    unique case (state_r)
      ST_MUL_R: begin
        op_a = lifet_pkg::op_t'(work_r);
        op_b = lifet_pkg::op_t'(resist_r);
      end
      ST_MUL_D: begin
        op_a = lifet_pkg::op_t'({1'b0, mdecay_r});
        op_b = lifet_pkg::op_t'(work_r);
      end
      default: begin
        op_a = lifet_pkg::op_t'(error_r);
        op_b = lifet_pkg::op_t'({1'b0, edecay_r});
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    voltage_nxt   = voltage_r;
    error_nxt     = error_r;
    cnt_nxt       = cnt_r;
    work_nxt      = work_r;
    alpha_nxt     = alpha_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_if.mode) begin
            voltage_nxt = reset_v_r;
            cnt_nxt     = refrac_r;
            error_nxt   = lifet_pkg::sat_sum(lifet_pkg::sx(error_r)
                                             + lifet_pkg::sx(lifet_pkg::FX_ONE));
            state_nxt   = ST_FIN;
          end else if (cnt_r != '0) begin
            cnt_nxt   = cnt_r - 1'b1;
            state_nxt = ST_MUL_E;
          end else begin
            state_nxt = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        work_nxt  = lifet_pkg::sat_sum(lifet_pkg::sx(exc_r) - lifet_pkg::sx(inh_r)
                                       + lifet_pkg::sx(bias_r) + lifet_pkg::sx(offset_r));
        state_nxt = ST_MUL_R;
      end
      ST_MUL_R: state_nxt = ST_ALPHA;
      ST_ALPHA: begin
        alpha_nxt = lifet_pkg::sat_sum(lifet_pkg::sx(mul_res) + lifet_pkg::sx(rest_r));
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        work_nxt  = lifet_pkg::sat_sum(lifet_pkg::sx(alpha_r) - lifet_pkg::sx(voltage_r));
        state_nxt = ST_MUL_D;
      end
      ST_MUL_D: state_nxt = ST_VOLT;
      ST_VOLT: begin
        // error product launched here as well
        voltage_nxt = lifet_pkg::sat_sum(lifet_pkg::sx(alpha_r) - lifet_pkg::sx(mul_res));
        state_nxt   = ST_ERR_WB;
      end
      ST_MUL_E: state_nxt = ST_ERR_WB;
      ST_ERR_WB: begin
        error_nxt = mul_res;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      voltage_r   <= '0;
      error_r     <= '0;
      cnt_r       <= '0;
      rest_r      <= '0;
      reset_v_r   <= '0;
      offset_r    <= '0;
      resist_r    <= lifet_pkg::FX_ONE;
      mdecay_r    <= '0;
      edecay_r    <= '0;
      refrac_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      voltage_r   <= voltage_nxt;
      error_r     <= error_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          lifet_pkg::REG_REST_V:    rest_r    <= cfg_wdata;
          lifet_pkg::REG_RESET_V:   reset_v_r <= cfg_wdata;
          lifet_pkg::REG_OFFSET_I:  offset_r  <= cfg_wdata;
          lifet_pkg::REG_RESIST:    resist_r  <= cfg_wdata;
          lifet_pkg::REG_MEM_DECAY: mdecay_r  <= cfg_wdata[lifet_pkg::DECAY_W-1:0];
          lifet_pkg::REG_ERR_DECAY: edecay_r  <= cfg_wdata[lifet_pkg::DECAY_W-1:0];
          lifet_pkg::REG_REFRAC:    refrac_r  <= cfg_wdata[lifet_pkg::CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    work_r  <= work_nxt;
    alpha_r <= alpha_nxt;
    if (in_acc) begin
      exc_r  <= in_if.excitatory_current;
      inh_r  <= in_if.inhibitory_current;
      bias_r <= in_if.bias_current;
    end
    if (state_r == ST_FIN && slot_free) begin
      out_v_r <= voltage_r;
      out_e_r <= error_r;
    end
  end

  a_spike_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_if.mode) |=> (voltage_r == $past(reset_v_r) && cnt_r == $past(refrac_r)))
    else $error("spike did not reload voltage and count");

  a_refrac_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_if.mode && cnt_r != '0) |=>
      (cnt_r == $past(cnt_r) - 1'b1 && voltage_r == $past(voltage_r)))
    else $error("refractory step changed voltage or miscounted");

  a_err_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ERR_WB) |=> (error_r == $past(mul_res) && state_r == ST_FIN))
    else $error("error trace not written from shared unit");

  a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && slot_free) |=>
      (out_valid_r && out_v_r == $past(voltage_r) && out_e_r == $past(error_r)))
    else $error("result register not loaded");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_acc)
    else $error("item accepted while busy");

endmodule
`default_nettype wire

FILE: tb/tb_lif_neuron_with_error_trace_core.sv
`default_nettype none
module tb_lif_neuron_with_error_trace_core;
  import lifet_pkg::*;

  localparam logic MODE_STEP  = 1'b0;
  localparam logic MODE_SPIKE = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_ITEMS   = 200;

  typedef struct {
    logic  mode;
    word_t exc;
    word_t inh;
    word_t bias;
  } stim_t;

  typedef struct {
    word_t volt;
    word_t err;
  } neuron_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0] cfg_wdata = '0;

  lifet_in_if  in_ch();
  lifet_out_if out_ch();

  lif_neuron_with_error_trace_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // neuron registers as the predictor sees them
  word_t       rest_v   = '0;
  word_t       spike_v  = '0;
  word_t       offset_i = '0;
  word_t       resist   = word_t'(32768);
  logic [15:0] mem_decay = '0;
  logic [15:0] err_decay = '0;
  logic [15:0] refrac_len = '0;

  // neuron state
  word_t       mem_v = '0;
  logic [16:0] refrac_left = '0;
  word_t       err_tr = '0;

  stim_t       stim_backlog[$];
  neuron_out_t predicted_outs[$];

  int send_idle_pct = 19;
  int recv_idle_pct = 77;
  logic in_acc = 1'b0;

  int items_taken = 0;
  int spikes_taken = 0;
  int refrac_steps_seen = 0;
  int results_seen = 0;
  int mismatches = 0;
  int settings_used = 0;

  function automatic word_t clamp_word(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    else if (v < -64'sd2147483648) return 32'h8000_0000;
    else return v[31:0];
  endfunction

  function automatic word_t fx_product(input longint a, input longint b);
    longint p;
    p = a * b;
    return clamp_word(p >>> FRAC_BITS);
  endfunction

  task automatic advance_neuron(input stim_t it);
    longint acc;
    word_t cur, alpha, diff, pulled;
    neuron_out_t r;
    if (it.mode == MODE_SPIKE) begin
      mem_v = spike_v;
      refrac_left = refrac_len;
      acc = err_tr;
      acc = acc + (64'sd1 <<< FRAC_BITS);
      err_tr = clamp_word(acc);
      spikes_taken++;
    end else begin
      if (refrac_left == 0) begin
        acc = it.exc;
        acc = acc - it.inh;
        acc = acc + it.bias;
        acc = acc + offset_i;
        cur = clamp_word(acc);
        acc = fx_product(cur, resist);
        acc = acc + rest_v;
        alpha = clamp_word(acc);
        acc = alpha;
        acc = acc - mem_v;
        diff = clamp_word(acc);
        pulled = fx_product(mem_decay, diff);
        acc = alpha;
        acc = acc - pulled;
        mem_v = clamp_word(acc);
      end else begin
        refrac_left = refrac_left - 1'b1;
        refrac_steps_seen++;
      end
      err_tr = fx_product(err_tr, err_decay);
    end
    r.volt = mem_v;
    r.err = err_tr;
    predicted_outs.push_back(r);
  endtask

  task automatic compare_field(input string field, input word_t want, input word_t got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %h, got %h", field, want, got);
    end
  endtask

  function automatic word_t rand_current();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 65) return word_t'(int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
    else if (pick < 90) return word_t'($urandom);
    case ($urandom_range(4))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return '0;
      3: return '1;
      default: return word_t'(1);
    endcase
  endfunction

  function automatic void push_stim(input logic mode, input word_t e, input word_t i,
                                    input word_t b);
    stim_t s;
    s.mode = mode;
    s.exc = e;
    s.inh = i;
    s.bias = b;
    stim_backlog.push_back(s);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_REST_V:    rest_v = val;
      REG_RESET_V:   spike_v = val;
      REG_OFFSET_I:  offset_i = val;
      REG_RESIST:    resist = val;
      REG_MEM_DECAY: mem_decay = val[15:0];
      REG_ERR_DECAY: err_decay = val[15:0];
      REG_REFRAC:    refrac_len = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input word_t rv, input word_t sv, input word_t oi, input word_t rs,
                            input logic [31:0] md, input logic [31:0] ed,
                            input logic [31:0] rf);
    write_reg(REG_REST_V, rv);
    write_reg(REG_RESET_V, sv);
    write_reg(REG_OFFSET_I, oi);
    write_reg(REG_RESIST, rs);
    write_reg(REG_MEM_DECAY, md);
    write_reg(REG_ERR_DECAY, ed);
    write_reg(REG_REFRAC, rf);
    settings_used++;
  endtask

  // wait until nothing is queued, presented or outstanding, then let the core go quiet
  task automatic settle();
    do @(posedge clk);
    while (stim_backlog.size() != 0 || in_ch.valid || predicted_outs.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int kind, input int n, input int s_idle, input int r_idle);
    settle();
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    case (kind)
      0: set_config($urandom, $urandom, $urandom, $urandom,
                    {16'($urandom), 16'($urandom_range(0, 32768))},
                    {16'($urandom), 16'($urandom_range(0, 32768))},
                    $urandom_range(0, 4));
      1: set_config(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 32'hFFFF, 32'hFFFF, 32'hFFFF);
      2: set_config(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, '0, '0, '0);
      default: set_config(word_t'(int'($urandom_range(0, 140 << 15)) - (70 << 15)),
                          word_t'(int'($urandom_range(0, 140 << 15)) - (70 << 15)),
                          word_t'(int'($urandom_range(0, 4 << 15)) - (2 << 15)),
                          word_t'($urandom_range(0, 4 << 15)),
                          $urandom_range(0, 32768), $urandom_range(24576, 32768),
                          $urandom_range(0, 3));
    endcase
    repeat (n) push_stim($urandom_range(99) < 12 ? MODE_SPIKE : MODE_STEP,
                         rand_current(), rand_current(), rand_current());
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin : take_in
    in_acc <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      stim_t s;
      s.mode = in_ch.mode;
      s.exc = in_ch.excitatory_current;
      s.inh = in_ch.inhibitory_current;
      s.bias = in_ch.bias_current;
      items_taken++;
      advance_neuron(s);
    end
  end

  always @(negedge clk) begin : drive_in
    stim_t nxt;
    if (in_ch.valid && !in_acc) begin
      // item still waiting for ready
    end else if (rst_n && stim_backlog.size() != 0 &&
                 $urandom_range(99) >= send_idle_pct) begin
      nxt = stim_backlog.pop_front();
      in_ch.valid <= 1'b1;
      in_ch.mode <= nxt.mode;
      in_ch.excitatory_current <= nxt.exc;
      in_ch.inhibitory_current <= nxt.inh;
      in_ch.bias_current <= nxt.bias;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin : drive_ready
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_out
    neuron_out_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (predicted_outs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: voltage %h, error trace %h",
                   out_ch.membrane_voltage, out_ch.error_trace);
      end else begin
        want = predicted_outs.pop_front();
        compare_field("membrane_voltage", want.volt, out_ch.membrane_voltage);
        compare_field("error_trace", want.err, out_ch.error_trace);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL lif_neuron_with_error_trace_core");
    $finish;
  end

  initial begin
    int kinds[8];
    kinds = '{3, 1, 0, 3, 2, 3, 0, 3};
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_STEP;
    in_ch.excitatory_current = '0;
    in_ch.inhibitory_current = '0;
    in_ch.bias_current = '0;
    out_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: unit resistance, decay factors of zero
    push_stim(MODE_STEP, FX_ONE, '0, '0);
    push_stim(MODE_STEP, WORD_MAX, WORD_MIN, WORD_MAX);
    push_stim(MODE_STEP, WORD_MIN, WORD_MAX, WORD_MIN);
    push_stim(MODE_SPIKE, $urandom, $urandom, $urandom);
    push_stim(MODE_STEP, '0, '0, '0);
    settle();

    set_config(word_t'(-65 * 32768), word_t'(-70 * 32768), word_t'(16384),
               word_t'(2 * 32768), 32'h4000, 32'h7000, 32'd2);
    push_stim(MODE_SPIKE, $urandom, $urandom, $urandom);
    push_stim(MODE_STEP, word_t'(3 << 15), FX_ONE, '0);
    push_stim(MODE_STEP, word_t'(3 << 15), FX_ONE, '0);
    push_stim(MODE_STEP, word_t'(3 << 15), FX_ONE, FX_ONE);
    push_stim(MODE_STEP, WORD_MAX, '0, WORD_MAX);
    push_stim(MODE_STEP, WORD_MIN, word_t'(1), '0);
    settle();

    // new spike voltage only shows after the next spike; index 7 is dropped
    write_reg(REG_RESET_V, word_t'(5 << 15));
    write_reg(REG_UNUSED, $urandom);
    push_stim(MODE_STEP, FX_ONE, '0, '1);
    push_stim(MODE_SPIKE, '0, '0, '0);
    settle();

    // decay factors near 2.0 drive products into saturation
    set_config('0, '0, '0, WORD_MIN, 32'hFFFF, 32'hFFFF, '0);
    push_stim(MODE_SPIKE, $urandom, $urandom, $urandom);
    push_stim(MODE_STEP, FX_ONE, '0, '0);
    push_stim(MODE_STEP, WORD_MIN, '0, '0);
    push_stim(MODE_STEP, WORD_MAX, WORD_MIN, '0);
    push_stim(MODE_STEP, '1, '1, '1);
    push_stim(MODE_STEP, '0, '0, '0);

    for (int p = 0; p < 8; p++)
      run_phase(kinds[p], PHASE_ITEMS, p < 3 ? 19 : (p < 6 ? 77 : 0),
                p < 3 ? 77 : (p < 6 ? 19 : 0));
    settle();

    $display("Covered %0d items, %0d of them spikes, %0d refractory steps, %0d register sets",
             items_taken, spikes_taken, refrac_steps_seen, settings_used);
    $display("Compared %0d results, %0d field mismatches", results_seen, mismatches);
    if (mismatches == 0 && predicted_outs.size() == 0) begin
      $display("PASS lif_neuron_with_error_trace_core");
    end else begin
      $display("FAIL lif_neuron_with_error_trace_core");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
hdl/lifet_pkg.sv
hdl/lifet_in_if.sv
hdl/lifet_out_if.sv
hdl/lifet_mul.sv
hdl/lif_neuron_with_error_trace_core.sv
tb/tb_lif_neuron_with_error_trace_core.sv
